### rtl/ugnb_pkg.sv
// Shared types, constants and helpers of the uniform grid binning core.
// No dependencies; every other file of the block but ugnb_ram imports this package.
package ugnb_pkg;

    // Default geometry of the grid
    localparam int P_MAX_ROWS     = 16;
    localparam int P_MAX_COLUMNS  = 16;
    localparam int P_BUCKET_DEPTH = 4;

    // Query output limit and field widths
    localparam int MAX_RESULTS = 36;
    localparam int N_W         = 6;
    localparam int ID_W        = 16;
    localparam int POS_W       = 16;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WORLD_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WORLD_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT  = 2'd3;

    // Reset register values
    localparam logic [CFG_W-1:0] RST_WORLD = 16'd1024;
    localparam logic [CFG_W-1:0] RST_CELL  = 16'd64;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    // Operand pair fed to the shared divider
    typedef enum logic [1:0] {
        DS_COLS = 2'd0,
        DS_ROWS = 2'd1,
        DS_POSX = 2'd2,
        DS_POSY = 2'd3
    } t_div_sel;

    // Controller to datapath commands
    typedef struct packed {
        logic     accept;
        logic     div_start;
        t_div_sel div_sel;
        logic     store_cols;
        logic     store_rows;
        logic     store_col;
        logic     store_row;
        logic     fill_rd_home;
        logic     fill_rd_nb;
        logic     ins_wr;
        logic     clear_all;
        logic     e_load;
        logic     id_rd;
        logic     emit_pend;
        logic     load_pend;
        logic     nb_advance;
        logic     out_single;
        logic     out_pend_last;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic dirty;
        t_op  op;
        logic div_done;
        logic out_free;
        logic in_grid;
        logic fill_take;
        logic more;
        logic last_nb;
        logic pend_valid;
    } t_sts;

    // Address width that stays at least one bit
    function automatic int clog2s(input int v);
        return (v <= 2) ? 1 : $clog2(v);
    endfunction

endpackage

### rtl/ugnb_in_if.sv
// Input item channel: valid/ready handshake with the command payload.
// Depends on ugnb_pkg for field widths.
interface ugnb_in_if;
    import ugnb_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [1:0]              operation;
    logic [ID_W-1:0]         object_id;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;

    modport source (output valid, operation, object_id, pos_x, pos_y, input ready);
    modport sink   (input valid, operation, object_id, pos_x, pos_y, output ready);
endinterface

### rtl/ugnb_out_if.sv
// Result item channel: valid/ready handshake with the result payload.
// Depends on ugnb_pkg for field widths.
interface ugnb_out_if;
    import ugnb_pkg::*;
    logic            valid;
    logic            ready;
    logic [ID_W-1:0] found_id;
    logic            found_valid;
    logic            status;
    logic            last;

    modport source (output valid, found_id, found_valid, status, last, input ready);
    modport sink   (input valid, found_id, found_valid, status, last, output ready);
endinterface

### rtl/ugnb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ugnb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH <= 2) ? 1 : $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/ugnb_div.sv
// Restoring divider, one quotient bit per cycle, 16-bit unsigned operands.
// Depends on ugnb_pkg.
module ugnb_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_dividend,
    input  logic [15:0] i_divisor,
    output logic        o_done,
    output logic [15:0] o_quotient
);
    import ugnb_pkg::*;

    logic [15:0] r_rem, n_rem;
    logic [15:0] r_quo, n_quo;
    logic [15:0] r_dvs;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [16:0] w_trial;
    logic [16:0] w_shift;

    // One shift-subtract step
    always_comb begin
        w_shift = {r_rem, r_quo[15]};
        w_trial = w_shift - {1'b0, r_dvs};
        n_quo   = {r_quo[14:0], ~w_trial[16]};
        n_rem   = w_trial[16] ? w_shift[15:0] : w_trial[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= 5'd16;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 5'd1;
            if (r_cnt == 5'd1) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

### rtl/ugnb_ctrl.sv
// Controller state machine: sequences counts, binning, insert, clear, query walk.
// Depends on ugnb_pkg (t_cmd, t_sts, t_op).
module ugnb_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  ugnb_pkg::t_sts  i_sts,
    output ugnb_pkg::t_cmd  o_cmd
);
    import ugnb_pkg::*;

    typedef enum logic [17:0] {
        S_IDLE   = 18'h00001,
        S_CW_GO  = 18'h00002,
        S_CW_WT  = 18'h00004,
        S_CH_GO  = 18'h00008,
        S_CH_WT  = 18'h00010,
        S_DX_GO  = 18'h00020,
        S_DX_WT  = 18'h00040,
        S_DY_GO  = 18'h00080,
        S_DY_WT  = 18'h00100,
        S_INS_RD = 18'h00200,
        S_INS_WR = 18'h00400,
        S_CLR    = 18'h00800,
        S_RESP   = 18'h01000,
        S_Q_CELL = 18'h02000,
        S_Q_FILL = 18'h04000,
        S_Q_RD   = 18'h08000,
        S_Q_EMIT = 18'h10000,
        S_Q_END  = 18'h20000
    } t_state;

    t_state r_state, n_state;
    t_cmd   w_cmd;

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_sts.dirty) begin
                    n_state = S_CW_GO;
                end else begin
                    o_ready = 1'b1;
                    if (i_valid) begin
                        w_cmd.accept = 1'b1;
                        n_state = S_DX_GO;
                    end
                end
            end
            S_CW_GO: begin
                w_cmd.div_start = 1'b1;
                w_cmd.div_sel   = DS_COLS;
                n_state = S_CW_WT;
            end
            S_CW_WT: begin
                if (i_sts.div_done) begin
                    w_cmd.store_cols = 1'b1;
                    n_state = S_CH_GO;
                end
            end
            S_CH_GO: begin
                w_cmd.div_start = 1'b1;
                w_cmd.div_sel   = DS_ROWS;
                n_state = S_CH_WT;
            end
            S_CH_WT: begin
                if (i_sts.div_done) begin
                    w_cmd.store_rows = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_DX_GO: begin
                // latched operation decides the path
                unique case (i_sts.op)
                    OP_INSERT, OP_QUERY: begin
                        w_cmd.div_start = 1'b1;
                        w_cmd.div_sel   = DS_POSX;
                        n_state = S_DX_WT;
                    end
                    OP_CLEAR: n_state = S_CLR;
                    default:  n_state = S_IDLE;
                endcase
            end
            S_DX_WT: begin
                if (i_sts.div_done) begin
                    w_cmd.store_col = 1'b1;
                    n_state = S_DY_GO;
                end
            end
            S_DY_GO: begin
                w_cmd.div_start = 1'b1;
                w_cmd.div_sel   = DS_POSY;
                n_state = S_DY_WT;
            end
            S_DY_WT: begin
                if (i_sts.div_done) begin
                    w_cmd.store_row = 1'b1;
                    n_state = (i_sts.op == OP_INSERT) ? S_INS_RD : S_Q_CELL;
                end
            end
            S_INS_RD: begin
                w_cmd.fill_rd_home = 1'b1;
                n_state = S_INS_WR;
            end
            S_INS_WR: begin
                w_cmd.ins_wr = 1'b1;
                n_state = S_RESP;
            end
            S_CLR: begin
                w_cmd.clear_all = 1'b1;
                n_state = S_RESP;
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    w_cmd.out_single = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_Q_CELL: begin
                if (i_sts.in_grid) begin
                    w_cmd.fill_rd_nb = 1'b1;
                    n_state = S_Q_FILL;
                end else begin
                    w_cmd.nb_advance = 1'b1;
                    n_state = i_sts.last_nb ? S_Q_END : S_Q_CELL;
                end
            end
            S_Q_FILL: begin
                if (i_sts.fill_take) begin
                    w_cmd.e_load = 1'b1;
                    n_state = S_Q_RD;
                end else begin
                    w_cmd.nb_advance = 1'b1;
                    n_state = i_sts.last_nb ? S_Q_END : S_Q_CELL;
                end
            end
            S_Q_RD: begin
                w_cmd.id_rd = 1'b1;
                n_state = S_Q_EMIT;
            end
            S_Q_EMIT: begin
                // previous hit goes out before the new one is held
                if (!i_sts.pend_valid || i_sts.out_free) begin
                    w_cmd.emit_pend = i_sts.pend_valid;
                    w_cmd.load_pend = 1'b1;
                    if (i_sts.more) begin
                        n_state = S_Q_RD;
                    end else begin
                        w_cmd.nb_advance = 1'b1;
                        n_state = i_sts.last_nb ? S_Q_END : S_Q_CELL;
                    end
                end
            end
            S_Q_END: begin
                if (!i_sts.pend_valid) begin
                    n_state = S_RESP;
                end else if (i_sts.out_free) begin
                    w_cmd.out_pend_last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd = w_cmd;
endmodule

### rtl/ugnb_dp.sv
// Datapath: config registers, grid counts, divider, bucket memories, output register.
// Depends on ugnb_pkg, ugnb_div and ugnb_ram.
module ugnb_dp #(
    parameter int MAX_ROWS     = ugnb_pkg::P_MAX_ROWS,
    parameter int MAX_COLUMNS  = ugnb_pkg::P_MAX_COLUMNS,
    parameter int BUCKET_DEPTH = ugnb_pkg::P_BUCKET_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ugnb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ugnb_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic [1:0]                        i_operation,
    input  logic [ugnb_pkg::ID_W-1:0]         i_object_id,
    input  logic signed [ugnb_pkg::POS_W-1:0] i_pos_x,
    input  logic signed [ugnb_pkg::POS_W-1:0] i_pos_y,
    input  ugnb_pkg::t_cmd                    i_cmd,
    output ugnb_pkg::t_sts                    o_sts,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [ugnb_pkg::ID_W-1:0]         o_found_id,
    output logic                              o_found_valid,
    output logic                              o_status,
    output logic                              o_last
);
    import ugnb_pkg::*;

    localparam int NUM_CELLS = MAX_ROWS * MAX_COLUMNS;
    localparam int NUM_IDS   = NUM_CELLS * BUCKET_DEPTH;
    localparam int ROW_W     = clog2s(MAX_ROWS);
    localparam int COL_W     = clog2s(MAX_COLUMNS);
    localparam int RCNT_W    = clog2s(MAX_ROWS + 1);
    localparam int CCNT_W    = clog2s(MAX_COLUMNS + 1);
    localparam int CELL_W    = clog2s(NUM_CELLS);
    localparam int IDA_W     = clog2s(NUM_IDS);
    localparam int FILL_W    = clog2s(BUCKET_DEPTH + 1);
    localparam int NB_RW     = RCNT_W + 2;
    localparam int NB_CW     = CCNT_W + 2;

    // Configuration registers
    logic [CFG_W-1:0] r_world_w, r_world_h, r_cell_w, r_cell_h;
    logic             r_dirty;
    logic [RCNT_W-1:0] r_rows;
    logic [CCNT_W-1:0] r_cols;

    // Item registers
    t_op              r_op;
    logic [ID_W-1:0]  r_id;
    logic [POS_W-1:0] r_px, r_py;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    logic             r_status;

    // Query walk registers
    logic [1:0]        r_dr, r_dc;
    logic [CELL_W-1:0] r_cell;
    logic [FILL_W-1:0] r_e;
    logic [N_W-1:0]    r_n;
    logic              r_pend_valid;
    logic [ID_W-1:0]   r_pend_id;
    logic [NUM_CELLS-1:0] r_cell_valid;

    // Output register
    logic            r_out_valid;
    logic [ID_W-1:0] r_out_id;
    logic            r_out_fv, r_out_st, r_out_last;

    logic [15:0] w_dividend, w_divisor, w_quo;
    logic        w_div_done;
    logic [15:0] w_cnt_q;
    logic [CELL_W-1:0] w_home, w_nb_cell, w_fill_raddr, w_fill_waddr;
    logic [FILL_W-1:0] w_fill_rdata, w_fill_now, w_e_eff;
    logic [ID_W-1:0]   w_id_rdata;
    logic [IDA_W-1:0]  w_id_raddr, w_id_waddr;
    logic signed [NB_RW-1:0] w_nr;
    logic signed [NB_CW-1:0] w_nc;
    logic w_in_grid, w_ins_ok, w_out_free;
    logic [N_W-1:0] w_n_inc;

    // Divider operand select; a zero cell size acts as one
    always_comb begin
        unique case (i_cmd.div_sel)
            DS_COLS: begin w_dividend = r_world_w; w_divisor = r_cell_w; end
            DS_ROWS: begin w_dividend = r_world_h; w_divisor = r_cell_h; end
            DS_POSX: begin w_dividend = r_px;      w_divisor = r_cell_w; end
            DS_POSY: begin w_dividend = r_py;      w_divisor = r_cell_h; end
            default: begin w_dividend = r_px;      w_divisor = r_cell_w; end
        endcase
        if (w_divisor == '0) begin
            w_divisor = 16'd1;
        end
    end

    ugnb_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // Grid count: quotient at least one
    assign w_cnt_q = (w_quo == '0) ? 16'd1 : w_quo;

    // Config writes and derived counts; a write after the count pass
    // has taken its operands marks the counts stale again
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_world_w <= RST_WORLD;
            r_world_h <= RST_WORLD;
            r_cell_w  <= RST_CELL;
            r_cell_h  <= RST_CELL;
            r_dirty   <= 1'b1;
            r_rows    <= RCNT_W'(1);
            r_cols    <= CCNT_W'(1);
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_WORLD_WIDTH:  r_world_w <= i_cfg_data;
                    REG_WORLD_HEIGHT: r_world_h <= i_cfg_data;
                    REG_CELL_WIDTH:   r_cell_w  <= i_cfg_data;
                    REG_CELL_HEIGHT:  r_cell_h  <= i_cfg_data;
                    default: ;
                endcase
                r_dirty <= 1'b1;
            end else if (i_cmd.div_start && (i_cmd.div_sel == DS_COLS)) begin
                r_dirty <= 1'b0;
            end
            if (i_cmd.store_cols) begin
                r_cols <= (w_cnt_q > 16'(MAX_COLUMNS)) ? CCNT_W'(MAX_COLUMNS)
                                                       : w_cnt_q[CCNT_W-1:0];
            end
            if (i_cmd.store_rows) begin
                r_rows <= (w_cnt_q > 16'(MAX_ROWS)) ? RCNT_W'(MAX_ROWS)
                                                    : w_cnt_q[RCNT_W-1:0];
            end
        end
    end

    // Item capture and binning with clamp
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op <= t_op'(i_operation);
            r_id <= i_object_id;
            r_px <= i_pos_x;
            r_py <= i_pos_y;
        end
        if (i_cmd.store_col) begin
            if (r_px[POS_W-1]) begin
                r_col <= '0;
            end else if (w_quo >= 16'(r_cols)) begin
                r_col <= COL_W'(r_cols - CCNT_W'(1));
            end else begin
                r_col <= w_quo[COL_W-1:0];
            end
        end
        if (i_cmd.store_row) begin
            if (r_py[POS_W-1]) begin
                r_row <= '0;
            end else if (w_quo >= 16'(r_rows)) begin
                r_row <= ROW_W'(r_rows - RCNT_W'(1));
            end else begin
                r_row <= w_quo[ROW_W-1:0];
            end
        end
    end

    // Home cell and neighbour cell (offsets +1, 0, -1)
    always_comb begin
        w_home = CELL_W'(r_row) * CELL_W'(MAX_COLUMNS) + CELL_W'(r_col);
        w_nr   = NB_RW'(r_row) + NB_RW'(1) - NB_RW'(r_dr);
        w_nc   = NB_CW'(r_col) + NB_CW'(1) - NB_CW'(r_dc);
        w_in_grid = (w_nr >= 0) && (w_nr < $signed(NB_RW'(r_rows)))
                 && (w_nc >= 0) && (w_nc < $signed(NB_CW'(r_cols)));
        w_nb_cell = CELL_W'(w_nr[ROW_W-1:0]) * CELL_W'(MAX_COLUMNS)
                  + CELL_W'(w_nc[COL_W-1:0]);
    end

    // Bucket fill memory with one valid flag per cell
    assign w_fill_raddr = i_cmd.fill_rd_nb ? w_nb_cell : w_home;
    assign w_fill_waddr = w_home;
    assign w_fill_now   = r_cell_valid[w_home] ? w_fill_rdata : '0;
    assign w_ins_ok     = (w_fill_now < FILL_W'(BUCKET_DEPTH));

    ugnb_ram #(.WIDTH(FILL_W), .DEPTH(NUM_CELLS), .AW(CELL_W)) u_fill_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ins_wr && w_ins_ok),
        .i_waddr (w_fill_waddr),
        .i_wdata (w_fill_now + FILL_W'(1)),
        .i_raddr (w_fill_raddr),
        .o_rdata (w_fill_rdata)
    );

    // Bucket id memory; the read address holds still until the id is taken
    assign w_id_waddr = IDA_W'(w_home) * IDA_W'(BUCKET_DEPTH) + IDA_W'(w_fill_now);
    assign w_id_raddr = i_cmd.id_rd
                      ? IDA_W'(r_cell) * IDA_W'(BUCKET_DEPTH) + IDA_W'(r_e - FILL_W'(1))
                      : IDA_W'(r_cell) * IDA_W'(BUCKET_DEPTH) + IDA_W'(r_e);

    ugnb_ram #(.WIDTH(ID_W), .DEPTH(NUM_IDS), .AW(IDA_W)) u_id_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ins_wr && w_ins_ok),
        .i_waddr (w_id_waddr),
        .i_wdata (r_id),
        .i_raddr (w_id_raddr),
        .o_rdata (w_id_rdata)
    );

    // Entries of the visited cell, capped at bucket depth
    always_comb begin
        if (!r_cell_valid[r_cell]) begin
            w_e_eff = '0;
        end else if (w_fill_rdata > FILL_W'(BUCKET_DEPTH)) begin
            w_e_eff = FILL_W'(BUCKET_DEPTH);
        end else begin
            w_e_eff = w_fill_rdata;
        end
    end

    assign w_n_inc = r_n + N_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_valid <= '0;
        end else if (i_cmd.clear_all) begin
            r_cell_valid <= '0;
        end else if (i_cmd.ins_wr && w_ins_ok) begin
            r_cell_valid[w_home] <= 1'b1;
        end
    end

    // Walk state: neighbour index, entry count, pending hit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (i_cmd.accept || i_cmd.out_pend_last) begin
            r_pend_valid <= 1'b0;
        end else if (i_cmd.load_pend) begin
            r_pend_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_dr     <= '0;
            r_dc     <= '0;
            r_n      <= '0;
            r_status <= 1'b0;
        end
        if (i_cmd.ins_wr) begin
            r_status <= ~w_ins_ok;
        end
        if (i_cmd.fill_rd_nb) begin
            r_cell <= w_nb_cell;
        end
        if (i_cmd.e_load) begin
            r_e <= w_e_eff;
        end
        if (i_cmd.id_rd) begin
            r_e <= r_e - FILL_W'(1);
        end
        if (i_cmd.load_pend) begin
            r_pend_id <= w_id_rdata;
            r_n       <= w_n_inc;
        end
        if (i_cmd.nb_advance) begin
            if (r_dc == 2'd2) begin
                r_dc <= '0;
                r_dr <= r_dr + 2'd1;
            end else begin
                r_dc <= r_dc + 2'd1;
            end
        end
    end

    // Output register
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_single || i_cmd.emit_pend || i_cmd.out_pend_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_single) begin
            r_out_id   <= '0;
            r_out_fv   <= 1'b0;
            r_out_st   <= r_status;
            r_out_last <= 1'b1;
        end else if (i_cmd.emit_pend || i_cmd.out_pend_last) begin
            r_out_id   <= r_pend_id;
            r_out_fv   <= 1'b1;
            r_out_st   <= 1'b0;
            r_out_last <= i_cmd.out_pend_last;
        end
    end

    // Status to controller
    always_comb begin
        o_sts            = '0;
        o_sts.dirty      = r_dirty;
        o_sts.op         = r_op;
        o_sts.div_done   = w_div_done;
        o_sts.out_free   = w_out_free;
        o_sts.in_grid    = w_in_grid;
        o_sts.fill_take  = (w_e_eff != '0) && (r_n < N_W'(MAX_RESULTS));
        o_sts.more       = (r_e != '0) && (w_n_inc < N_W'(MAX_RESULTS));
        o_sts.last_nb    = (r_dr == 2'd2) && (r_dc == 2'd2);
        o_sts.pend_valid = r_pend_valid;
    end

    assign o_out_valid   = r_out_valid;
    assign o_found_id    = r_out_id;
    assign o_found_valid = r_out_fv;
    assign o_status      = r_out_st;
    assign o_last        = r_out_last;
endmodule

### rtl/uniform_grid_neighbour_binning_core.sv
// Uniform grid broad phase: insert, 3x3 neighbour query and clear.
// One item at a time; the two coordinate divisions on one shared divider
// and the cell walk set the rate. Reset is synchronous, active low; after
// reset and after each register write the grid counts are recomputed
// before the next item is accepted.
module uniform_grid_neighbour_binning_core #(
    parameter int MAX_ROWS     = ugnb_pkg::P_MAX_ROWS,
    parameter int MAX_COLUMNS  = ugnb_pkg::P_MAX_COLUMNS,
    parameter int BUCKET_DEPTH = ugnb_pkg::P_BUCKET_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ugnb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ugnb_pkg::CFG_W-1:0]     i_cfg_data,
    ugnb_in_if.sink                        i_item,
    ugnb_out_if.source                     o_result
);
    import ugnb_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_ready;

    ugnb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_item.valid),
        .o_ready (w_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    ugnb_dp #(
        .MAX_ROWS     (MAX_ROWS),
        .MAX_COLUMNS  (MAX_COLUMNS),
        .BUCKET_DEPTH (BUCKET_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_operation   (i_item.operation),
        .i_object_id   (i_item.object_id),
        .i_pos_x       (i_item.pos_x),
        .i_pos_y       (i_item.pos_y),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_out_ready   (o_result.ready),
        .o_out_valid   (o_result.valid),
        .o_found_id    (o_result.found_id),
        .o_found_valid (o_result.found_valid),
        .o_status      (o_result.status),
        .o_last        (o_result.last)
    );

    assign i_item.ready = w_ready;
endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of uniform_grid_neighbour_binning_core: a grid model
// predicts each result item; needs ugnb_pkg, ugnb_in_if, ugnb_out_if and the core.
module testbench;
    import ugnb_pkg::*;

    localparam int ROWS_MAX  = P_MAX_ROWS;
    localparam int COLS_MAX  = P_MAX_COLUMNS;
    localparam int DEPTH     = P_BUCKET_DEPTH;
    localparam int IDLE_LIM  = 5000;
    localparam int HOLD_LEN  = 400;
    localparam int SETTLE    = 200;

    typedef struct {
        logic [1:0]        op;
        logic [ID_W-1:0]   id;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
    } t_cmd_item;

    typedef struct {
        logic [ID_W-1:0] id;
        logic            fvalid;
        logic            status;
        logic            last;
    } t_hit;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    ugnb_in_if  in_ch ();
    ugnb_out_if out_ch ();

    uniform_grid_neighbour_binning_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (in_ch.sink),
        .o_result   (out_ch.source)
    );

    // Grid model state
    int unsigned world_w, world_h, cell_w, cell_h, n_rows, n_cols;
    int unsigned fill_cnt [ROWS_MAX*COLS_MAX];
    logic [ID_W-1:0] cell_ids [ROWS_MAX*COLS_MAX*DEPTH];

    t_cmd_item pending_q[$];
    t_hit      hits_q[$];
    int errors, n_results, n_found, n_dropped, n_accepted;
    int hold_req, hold_done;

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    function automatic int unsigned grid_count(int unsigned world, int unsigned csize,
                                               int unsigned cap);
        int unsigned q;
        q = world / ((csize == 0) ? 1 : csize);
        if (q == 0) q = 1;
        if (q > cap) q = cap;
        return q;
    endfunction

    function automatic int unsigned bin_pos(logic [POS_W-1:0] p, int unsigned csize,
                                            int unsigned cnt);
        int unsigned q;
        if (p[POS_W-1]) return 0;
        q = p / ((csize == 0) ? 1 : csize);
        if (q >= cnt) q = cnt - 1;
        return q;
    endfunction

    // Apply one accepted item to the grid and queue the items it yields
    task automatic grid_apply(input t_cmd_item it);
        int unsigned col, row, cidx, e;
        int r, c, n;
        col = bin_pos(it.x, cell_w, n_cols);
        row = bin_pos(it.y, cell_h, n_rows);
        n = 0;
        if (it.op == OP_INSERT) begin
            cidx = row * COLS_MAX + col;
            if (fill_cnt[cidx] < DEPTH) begin
                cell_ids[cidx*DEPTH + fill_cnt[cidx]] = it.id;
                fill_cnt[cidx]++;
                hits_q.push_back('{0, 1'b0, 1'b0, 1'b1});
            end else begin
                hits_q.push_back('{0, 1'b0, 1'b1, 1'b1});
            end
        end else if (it.op == OP_QUERY) begin
            for (int dr = 1; dr >= -1; dr--) begin
                for (int dc = 1; dc >= -1; dc--) begin
                    r = int'(row) + dr;
                    c = int'(col) + dc;
                    if (r >= 0 && r < int'(n_rows) && c >= 0 && c < int'(n_cols)) begin
                        cidx = r * COLS_MAX + c;
                        e = fill_cnt[cidx];
                        while (e > 0 && n < MAX_RESULTS) begin
                            e--;
                            hits_q.push_back('{cell_ids[cidx*DEPTH + e], 1'b1, 1'b0, 1'b0});
                            n++;
                        end
                    end
                end
            end
            if (n == 0) hits_q.push_back('{0, 1'b0, 1'b0, 1'b1});
            else hits_q[hits_q.size()-1].last = 1'b1;
        end else if (it.op == OP_CLEAR) begin
            foreach (fill_cnt[i]) fill_cnt[i] = 0;
            hits_q.push_back('{0, 1'b0, 1'b0, 1'b1});
        end
        // operation code 3 yields nothing
    endtask

    task automatic report(input string what);
        errors++;
        $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    // Sender: bursts of random length separated by random gaps
    int burst_left, gap_left;
    always @(posedge i_clk) begin
        t_cmd_item it;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                it = pending_q.pop_front();
                grid_apply(it);
                n_accepted++;
                if (burst_left > 0) burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
                end
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_ch.valid <= 1'b0;
                end else if (pending_q.size() != 0) begin
                    in_ch.valid     <= 1'b1;
                    in_ch.operation <= pending_q[0].op;
                    in_ch.object_id <= pending_q[0].id;
                    in_ch.pos_x     <= pending_q[0].x;
                    in_ch.pos_y     <= pending_q[0].y;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall pattern that changes now and then, plus a long hold-off on request
    logic [7:0] stall_pat;
    int pat_age, hold_left;
    always @(posedge i_clk) begin
        t_hit exp_hit;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                n_results++;
                if (hits_q.size() == 0) begin
                    report($sformatf("unexpected item id=%h", out_ch.found_id));
                end else begin
                    exp_hit = hits_q.pop_front();
                    if (out_ch.found_id !== exp_hit.id)
                        report($sformatf("found_id %h, want %h", out_ch.found_id, exp_hit.id));
                    if (out_ch.found_valid !== exp_hit.fvalid)
                        report($sformatf("found_valid %b, want %b",
                                         out_ch.found_valid, exp_hit.fvalid));
                    if (out_ch.status !== exp_hit.status)
                        report($sformatf("status %b, want %b", out_ch.status, exp_hit.status));
                    if (out_ch.last !== exp_hit.last)
                        report($sformatf("last %b, want %b", out_ch.last, exp_hit.last));
                    if (exp_hit.fvalid) n_found++;
                    if (exp_hit.status) n_dropped++;
                end
            end
            pat_age++;
            if (pat_age >= 40) begin
                pat_age = 0;
                stall_pat = ($urandom_range(0, 2) == 0) ? 8'hff : 8'($urandom);
            end
            if (hold_done != hold_req) begin
                hold_done = hold_req;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= stall_pat[pat_age % 8];
            end
        end
    end

    // Watchdog: cycles without any handshake
    int idle_cycles;
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIM) begin
            $display("timeout: no progress for %0d cycles", IDLE_LIM);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic add_item(input logic [1:0] op, input logic [ID_W-1:0] id,
                            input logic [POS_W-1:0] x, input logic [POS_W-1:0] y);
        pending_q.push_back('{op, id, x, y});
    endtask

    task automatic wait_idle();
        while (pending_q.size() != 0 || hits_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_WORLD_WIDTH:  world_w = val;
            REG_WORLD_HEIGHT: world_h = val;
            REG_CELL_WIDTH:   cell_w  = val;
            default:          cell_h  = val;
        endcase
        n_rows = grid_count(world_h, cell_h, ROWS_MAX);
        n_cols = grid_count(world_w, cell_w, COLS_MAX);
    endtask

    function automatic logic [POS_W-1:0] rand_pos(input int unsigned world);
        int unsigned hi;
        hi = (world > 32767) ? 32767 : world;
        if ($urandom_range(0, 9) < 7) return POS_W'($urandom_range(0, hi));
        return POS_W'($urandom);
    endfunction

    // Random items, mostly inserts and queries on the current grid
    task automatic add_random(input int n);
        int k;
        logic [1:0] op;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            if (k < 50)      op = OP_INSERT;
            else if (k < 92) op = OP_QUERY;
            else if (k < 96) op = OP_CLEAR;
            else             op = 2'd3;
            add_item(op, ID_W'($urandom), rand_pos(world_w), rand_pos(world_h));
        end
    endtask

    initial begin
        int unsigned geo [6][4];
        geo = '{'{1024, 1024, 64, 64}, '{96, 96, 32, 32}, '{65535, 65535, 1, 1},
                '{1, 1, 65535, 65535}, '{500, 300, 0, 0}, '{200, 130, 70, 40}};
        errors = 0; n_results = 0; n_found = 0; n_dropped = 0; n_accepted = 0;
        hold_req = 0; hold_done = 0; hold_left = 0; idle_cycles = 0;
        burst_left = 1; gap_left = 0; stall_pat = 8'hff; pat_age = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0; i_cfg_idx = REG_WORLD_WIDTH; i_cfg_data = '0;
        in_ch.valid = 1'b0; in_ch.operation = OP_INSERT; in_ch.object_id = '0;
        in_ch.pos_x = '0; in_ch.pos_y = '0;
        out_ch.ready = 1'b0;
        world_w = RST_WORLD; world_h = RST_WORLD; cell_w = RST_CELL; cell_h = RST_CELL;
        n_rows = grid_count(world_h, cell_h, ROWS_MAX);
        n_cols = grid_count(world_w, cell_w, COLS_MAX);
        foreach (fill_cnt[i]) fill_cnt[i] = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty query, field extremes, full bucket drop, op 3, clear
        add_item(OP_QUERY, 16'h0000, 16'sd100, 16'sd100);
        add_item(OP_INSERT, 16'h0000, 16'h8000, 16'h8000);
        add_item(OP_INSERT, 16'hffff, 16'h7fff, 16'h7fff);
        add_item(OP_INSERT, 16'h5555, 16'd0, 16'd0);
        add_item(OP_INSERT, 16'haaaa, 16'd63, 16'd63);
        add_item(OP_INSERT, 16'h1234, 16'hffff, 16'd1);
        add_item(OP_INSERT, 16'h4321, 16'd10, 16'd10);
        add_item(OP_QUERY, 16'hffff, 16'h8000, 16'h8000);
        add_item(OP_QUERY, 16'h0000, 16'h7fff, 16'h7fff);
        add_item(OP_INSERT, 16'h0f0f, 16'd64, 16'd64);
        add_item(OP_QUERY, 16'h0000, 16'd40, 16'd40);
        add_item(2'd3, 16'hffff, 16'h7fff, 16'h8000);
        add_item(OP_QUERY, 16'h0000, 16'd960, 16'd0);
        add_item(OP_CLEAR, 16'h0000, 16'd0, 16'd0);
        add_item(OP_QUERY, 16'h0000, 16'd0, 16'd0);
        add_random(10);
        // Long receiver hold-off while the sender keeps offering items
        while (pending_q.size() > 8) @(posedge i_clk);
        hold_req++;
        add_random(10);
        wait_idle();

        // Further grid settings, extremes among them
        for (int p = 1; p < 6; p++) begin
            write_reg(REG_WORLD_WIDTH,  CFG_W'(geo[p][0]));
            write_reg(REG_WORLD_HEIGHT, CFG_W'(geo[p][1]));
            write_reg(REG_CELL_WIDTH,   CFG_W'(geo[p][2]));
            write_reg(REG_CELL_HEIGHT,  CFG_W'(geo[p][3]));
            add_random(p == 1 ? 45 : 20);
            wait_idle();
        end

        $display("covered %0d items in 6 grid settings: %0d result items, %0d ids found,",
                 n_accepted, n_results, n_found);
        $display("%0d dropped inserts, one long receiver hold-off", n_dropped);
        if (hits_q.size() != 0)
            report($sformatf("%0d result items never arrived", hits_q.size()));
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
